// ===== sv/imds_pkg.sv =====
// Shared types and constants for the Ising Metropolis damage spreading unit.
// No dependencies; every other file refers to this package by scoped names.
package imds_pkg;

  localparam int NODES = 64;
  localparam int NODE_W = 6;
  localparam int ROW_W = 64;
  localparam int CNT_W = 7;
  localparam int FRAC_W = 16;
  localparam int STEP_W = 7;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [ROW_W-1:0] NODE_MASK =
    (NODES >= ROW_W) ? {ROW_W{1'b1}} : ((ROW_W'(1) << NODES) - ROW_W'(1));

  typedef enum logic [1:0] {
    OP_WR_ROW   = 2'd0,
    OP_WR_SPIN  = 2'd1,
    OP_UPDATE   = 2'd2,
    OP_READ_CNT = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACCEPT_BASE = 1'b0,
    CFG_PINNED_NODE = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_G1,
    ST_G2,
    ST_G3,
    ST_G4,
    ST_SETUP,
    ST_POW,
    ST_CNT0,
    ST_CNT1,
    ST_DONE
  } state_t;

  // sequencer -> power unit
  typedef struct packed {
    logic              load;
    logic [STEP_W-1:0] steps;
  } pow_ctl_t;

  // power unit -> sequencer
  typedef struct packed {
    logic done;
    logic undo;
  } pow_sts_t;

endpackage

// ===== sv/ising_metropolis_damage_spreading_unit.sv =====
// Top level of the Ising Metropolis damage spreading unit: sequencer,
// adjacency memory and spin registers. Depends on imds_pkg, imds_popcnt, imds_pow.
//
// Usage
//   Commands: a beat is taken at a clock edge with start high and busy low.
//   in_operation selects: write adjacency row, write both spins of a node,
//   try a Metropolis flip of a node in main and replica, or read the count.
//   Every command gives exactly one result beat: out_valid is high for one
//   cycle with the node's spins after the command and the mismatch count.
//   Sequence: row write, spin write and count read step through CNT0, CNT1
//   and DONE to the strobe; the next command may be started in the strobe cycle.
//   An update gathers in READ and G1 to G4 (memory read and three popcounts
//   through one two-stage popcount tree), then per copy runs a setup step
//   and, for k > 0, power steps towards accept_base to the k-th power on the
//   shared 16x16 multiplier, where k = disagreeing minus agreeing neighbours,
//   finishing early once random exceeds the power; with k <= 0 the copy
//   flips at once. The pinned node is tried in the main copy only. Then
//   CNT0, CNT1 and DONE give the count.
//   The receiver cannot stall; results are dropped if not taken.
//   Configuration writes (cfg_we) take effect at once and belong in idle time.
//   Reset: accept_base returns to 27460 and pinned_node to 0; adjacency and
//   spins hold no defined value until written.
module ising_metropolis_damage_spreading_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      in_operation,
  input  logic [imds_pkg::NODE_W-1:0]     in_node,
  input  logic [imds_pkg::ROW_W-1:0]      in_row_bits,
  input  logic                            in_spin_main,
  input  logic                            in_spin_replica,
  input  logic [imds_pkg::FRAC_W-1:0]     in_random,
  output logic                            out_valid,
  output logic                            out_main_spin_now,
  output logic                            out_replica_spin_now,
  output logic [imds_pkg::CNT_W-1:0]      out_mismatch_count,
  input  logic                            cfg_we,
  input  logic [imds_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [imds_pkg::CFG_DATA_W-1:0] cfg_data
);

  imds_pkg::state_t state_r, state_nxt;
  imds_pkg::op_t    op;
  imds_pkg::pow_ctl_t pow_ctl;
  imds_pkg::pow_sts_t pow_sts;

  logic [imds_pkg::ROW_W-1:0]  adj_mem [imds_pkg::NODES];
  logic [imds_pkg::ROW_W-1:0]  rd_data_r;
  logic [imds_pkg::ROW_W-1:0]  main_r, rep_r;
  logic [imds_pkg::ROW_W-1:0]  nbr_r, nbr;
  logic [imds_pkg::ROW_W-1:0]  pc_vec;
  logic [imds_pkg::CNT_W-1:0]  pc_out;
  logic [imds_pkg::CNT_W-1:0]  total_r, diff_m_r, diff_r_r, diff_sel;
  logic [imds_pkg::NODE_W-1:0] node_r;
  logic [imds_pkg::FRAC_W-1:0] rnd_r;
  logic [imds_pkg::FRAC_W-1:0] base_r;
  logic [imds_pkg::NODE_W-1:0] pinned_r;
  logic                        valid_r;
  logic                        copy_r, copy_nxt;
  logic                        accept, node_valid;
  logic                        flip_en, flip_undo;
  logic signed [imds_pkg::CNT_W+1:0] k_s;
  logic                        k_pos;
  logic                        out_valid_r, out_main_r, out_rep_r;
  logic [imds_pkg::CNT_W-1:0]  out_cnt_r;

  assign op         = imds_pkg::op_t'(in_operation);
  assign accept     = start && (state_r == imds_pkg::ST_IDLE);
  assign node_valid = {1'b0, in_node} < imds_pkg::CNT_W'(imds_pkg::NODES);
  assign busy       = state_r != imds_pkg::ST_IDLE;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= imds_pkg::FRAC_W'(27460);
      pinned_r <= '0;
    end else if (cfg_we) begin
      unique case (imds_pkg::cfg_idx_t'(cfg_index))
        imds_pkg::CFG_ACCEPT_BASE: base_r   <= cfg_data;
        imds_pkg::CFG_PINNED_NODE: pinned_r <= cfg_data[imds_pkg::NODE_W-1:0];
        default: ;
      endcase
    end
  end

  // adjacency memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (accept && node_valid && op == imds_pkg::OP_WR_ROW) begin
      adj_mem[in_node] <= in_row_bits;
    end
    rd_data_r <= adj_mem[in_node];
  end

  // neighbours, self link and nodes past the end removed
  assign nbr = rd_data_r & imds_pkg::NODE_MASK & ~(imds_pkg::ROW_W'(1) << node_r);

  imds_popcnt u_popcnt (
    .clk   (clk),
    .vec   (pc_vec),
    .count (pc_out)
  );

  imds_pow u_pow (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (pow_ctl),
    .base  (base_r),
    .rnd   (rnd_r),
    .sts   (pow_sts)
  );

  assign diff_sel = copy_r ? diff_r_r : diff_m_r;
  // k = differ - agree = 2*differ - total
  assign k_s   = $signed({1'b0, diff_sel, 1'b0}) - $signed({2'b00, total_r});
  assign k_pos = !k_s[imds_pkg::CNT_W+1] && (k_s != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= imds_pkg::ST_IDLE;
      copy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      copy_r  <= copy_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    copy_nxt      = copy_r;
    pc_vec        = (main_r ^ rep_r) & imds_pkg::NODE_MASK;
    pow_ctl.load  = 1'b0;
    pow_ctl.steps = k_s[imds_pkg::STEP_W-1:0] - imds_pkg::STEP_W'(1);
    flip_en       = 1'b0;
    flip_undo     = 1'b0;
    unique case (state_r)
      imds_pkg::ST_IDLE: begin
        copy_nxt = 1'b0;
        if (start) begin
          state_nxt = (op == imds_pkg::OP_UPDATE && node_valid) ?
                      imds_pkg::ST_READ : imds_pkg::ST_CNT0;
        end
      end
      imds_pkg::ST_READ: begin
        pc_vec    = nbr;
        state_nxt = imds_pkg::ST_G1;
      end
      imds_pkg::ST_G1: begin
        pc_vec    = nbr_r & (main_r ^ {imds_pkg::ROW_W{main_r[node_r]}});
        state_nxt = imds_pkg::ST_G2;
      end
      imds_pkg::ST_G2: begin
        pc_vec    = nbr_r & (rep_r ^ {imds_pkg::ROW_W{rep_r[node_r]}});
        state_nxt = imds_pkg::ST_G3;
      end
      imds_pkg::ST_G3: state_nxt = imds_pkg::ST_G4;
      imds_pkg::ST_G4: state_nxt = imds_pkg::ST_SETUP;
      imds_pkg::ST_SETUP: begin
        if (k_pos) begin
          pow_ctl.load = 1'b1;
          state_nxt    = imds_pkg::ST_POW;
        end else begin
          flip_en = 1'b1;
          if (!copy_r && node_r != pinned_r) begin
            copy_nxt = 1'b1;
          end else begin
            state_nxt = imds_pkg::ST_CNT0;
          end
        end
      end
      imds_pkg::ST_POW: begin
        if (pow_sts.done) begin
          flip_en   = 1'b1;
          flip_undo = pow_sts.undo;
          if (!copy_r && node_r != pinned_r) begin
            copy_nxt  = 1'b1;
            state_nxt = imds_pkg::ST_SETUP;
          end else begin
            state_nxt = imds_pkg::ST_CNT0;
          end
        end
      end
      imds_pkg::ST_CNT0: state_nxt = imds_pkg::ST_CNT1;
      imds_pkg::ST_CNT1: state_nxt = imds_pkg::ST_DONE;
      imds_pkg::ST_DONE: state_nxt = imds_pkg::ST_IDLE;
      default:           state_nxt = imds_pkg::ST_IDLE;
    endcase
  end

  // spin copies
  always_ff @(posedge clk) begin
    if (accept && node_valid && op == imds_pkg::OP_WR_SPIN) begin
      main_r[in_node] <= in_spin_main;
      rep_r[in_node]  <= in_spin_replica;
    end
    if (flip_en) begin
      if (copy_r) begin
        rep_r[node_r]  <= rep_r[node_r] ^ ~flip_undo;
      end else begin
        main_r[node_r] <= main_r[node_r] ^ ~flip_undo;
      end
    end
  end

  // command beat and gathered counts
  always_ff @(posedge clk) begin
    if (accept) begin
      node_r  <= in_node;
      rnd_r   <= in_random;
      valid_r <= node_valid;
    end
    if (state_r == imds_pkg::ST_READ) nbr_r    <= nbr;
    if (state_r == imds_pkg::ST_G2)   total_r  <= pc_out;
    if (state_r == imds_pkg::ST_G3)   diff_m_r <= pc_out;
    if (state_r == imds_pkg::ST_G4)   diff_r_r <= pc_out;
  end

  // result beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= state_r == imds_pkg::ST_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == imds_pkg::ST_DONE) begin
      out_main_r <= valid_r & main_r[node_r];
      out_rep_r  <= valid_r & rep_r[node_r];
      out_cnt_r  <= pc_out;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_main_spin_now    = out_main_r;
  assign out_replica_spin_now = out_rep_r;
  assign out_mismatch_count   = out_cnt_r;

endmodule

// ===== sv/imds_popcnt.sv =====
// Two-stage registered population count over one 64-bit row.
// Depends on imds_pkg. Byte counts are registered first, then their sum.
module imds_popcnt (
  input  logic                      clk,
  input  logic [imds_pkg::ROW_W-1:0] vec,
  output logic [imds_pkg::CNT_W-1:0] count
);

  localparam int CHUNKS = imds_pkg::ROW_W / 8;

  logic [3:0] chunk_nxt [CHUNKS];
  logic [3:0] chunk_r   [CHUNKS];
  logic [imds_pkg::CNT_W-1:0] sum_nxt;
  logic [imds_pkg::CNT_W-1:0] sum_r;

  always_comb begin
    for (int c = 0; c < CHUNKS; c++) begin
      chunk_nxt[c] = '0;
      for (int b = 0; b < 8; b++) begin
        chunk_nxt[c] = chunk_nxt[c] + 4'(vec[c*8+b]);
      end
    end
  end

  always_comb begin
    sum_nxt = '0;
    for (int c = 0; c < CHUNKS; c++) begin
      sum_nxt = sum_nxt + imds_pkg::CNT_W'(chunk_r[c]);
    end
  end

  always_ff @(posedge clk) begin
    chunk_r <= chunk_nxt;
    sum_r   <= sum_nxt;
  end

  assign count = sum_r;

endmodule

// ===== sv/imds_pow.sv =====
// Shared 16x16 multiplier that raises accept_base to the k-th power, one
// truncated product a cycle, and compares it with the random fraction.
// Depends on imds_pkg.
module imds_pow (
  input  logic                        clk,
  input  logic                        rst_n,
  input  imds_pkg::pow_ctl_t          ctl,
  input  logic [imds_pkg::FRAC_W-1:0] base,
  input  logic [imds_pkg::FRAC_W-1:0] rnd,
  output imds_pkg::pow_sts_t          sts
);

  logic                          active_r;
  logic [imds_pkg::STEP_W-1:0]   steps_r;
  logic [imds_pkg::FRAC_W-1:0]   p_r;
  logic [2*imds_pkg::FRAC_W-1:0] prod;
  logic                          above;
  logic                          finish;

  assign prod   = p_r * base;
  assign above  = rnd > p_r;
  // the power only falls, so once random exceeds it the outcome is fixed
  assign finish = active_r && ((steps_r == '0) || above);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (ctl.load) begin
      active_r <= 1'b1;
    end else if (finish) begin
      active_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      p_r     <= base;
      steps_r <= ctl.steps;
    end else if (active_r && !finish) begin
      p_r     <= prod[2*imds_pkg::FRAC_W-1:imds_pkg::FRAC_W];
      steps_r <= steps_r - imds_pkg::STEP_W'(1);
    end
  end

  assign sts.done = finish;
  assign sts.undo = above;

endmodule

// ===== sv/imds_checker.sv =====
// Port-level checks for the Ising Metropolis damage spreading unit, and the
// bind that attaches them. Depends on imds_pkg and the top level.
module imds_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic                       out_valid,
  input logic [imds_pkg::CNT_W-1:0] out_mismatch_count
);

  // a taken command keeps the unit busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("command beat taken but busy not raised");

  // every finished command yields its result beat
  a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result beat");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result beat while still busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result beat repeated");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_mismatch_count <= imds_pkg::CNT_W'(imds_pkg::NODES))
    else $error("mismatch count beyond node count");

endmodule

bind ising_metropolis_damage_spreading_unit imds_checker u_imds_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .out_valid          (out_valid),
  .out_mismatch_count (out_mismatch_count)
);
